[rtl/esr_pkg.sv]
// Shared types, constants and codes for the ESC serial telemetry receiver.
// No dependencies; every other file in the block refers to this package by scoped name.
`default_nettype none

package esr_pkg;

  localparam int MOTORS = 4;
  localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [3:0] MOTORS_N = 4'(MOTORS);

  localparam logic [3:0] FRAME_LEN = 4'd10;
  localparam logic [3:0] LAST_BYTE = 4'd9;

  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam int         ERPM_W    = 23;     // 16-bit eRPM/100 times 100
  localparam int         RPM_SCALE = 100;

  localparam logic [15:0] RESET_TIMEOUT   = 16'd500;
  localparam logic [7:0]  RESET_PERIOD    = 8'd4;
  localparam logic [7:0]  RESET_POLEPAIRS = 8'd7;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_POLE_PAIRS = 2'd0,
    REG_REQ_PERIOD = 2'd1,
    REG_TIMEOUT    = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [2:0] motor_select;
  } in_item_t;

  typedef struct packed {
    logic        is_frame_report;
    logic        crc_ok;
    logic [2:0]  motor;
    logic [15:0] rpm;
    logic [15:0] supply_mv;
    logic [15:0] load_current;
    logic [7:0]  temp_c;
    logic        valid_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  pole_pairs;
    logic [7:0]  request_period;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/esc_serial_telemetry_receiver_unit.sv]
// A tick is handled in IDLE; bytes 0-8 each pass through the bit-serial CRC8;
// the tenth byte goes CHECK, DIV (23-step divider), STORE, EMIT; zero pole pairs
// skip DIV, a bad checksum skips DIV and STORE; a read goes READ, then EMIT.
// Throughput: one item at a time; the next is taken once the control FSM is idle.
// Reset (rst, synchronous): counters, frame capture, CRC, records and config
// return to their defaults; no result is pending.
`default_nettype none

module esc_serial_telemetry_receiver_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire esr_pkg::in_item_t   item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output esr_pkg::out_item_t       result,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int MW = esr_pkg::MIDX_W;

  esr_pkg::cfg_t      cfg;
  esr_pkg::state_e    state, state_next;
  esr_pkg::out_item_t res;

  logic [31:0]   tick_count;
  logic [7:0]    divider_count;
  logic [7:0]    div_cnt_inc;
  logic [MW-1:0] expected_motor;
  logic          frame_active;
  logic [3:0]    byte_index;
  logic [7:0]    frame_bytes [esr_pkg::FRAME_LEN];
  logic [2:0]    sel;

  logic [15:0] record_rpm     [esr_pkg::MOTORS];
  logic [15:0] record_voltage [esr_pkg::MOTORS];
  logic [15:0] record_current [esr_pkg::MOTORS];
  logic [7:0]  record_temp    [esr_pkg::MOTORS];
  logic        record_valid   [esr_pkg::MOTORS];
  logic [31:0] record_stamp   [esr_pkg::MOTORS];

  logic accept, tick, capture, crc_start, div_start, load_out;
  logic bad_frame, store, read_res, advance;
  logic crc_done, div_done;
  logic [7:0]  crc;
  logic [15:0] div_quot;
  logic [15:0] rpm_val;
  logic [esr_pkg::ERPM_W-1:0] erpm;
  logic [MW-1:0] sel_idx;
  logic [31:0]   age;

  esr_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  esr_crc8_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .clear(advance),
    .start(crc_start),
    .data (item.rx_byte),
    .done (crc_done),
    .crc  (crc)
  );

  // eRPM = raw * 100, loaded straight into the divider's shift register
  assign erpm = esr_pkg::ERPM_W'({frame_bytes[7], frame_bytes[8]}) *
                esr_pkg::ERPM_W'(esr_pkg::RPM_SCALE);

  esr_div_serial u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(erpm),
    .divisor (cfg.pole_pairs),
    .done    (div_done),
    .quotient(div_quot)
  );

  assign item_ready  = (state == esr_pkg::ST_IDLE);
  assign accept      = item_valid && item_ready;
  assign div_cnt_inc = divider_count + 8'd1;
  assign advance     = tick && (div_cnt_inc >= cfg.request_period);
  assign rpm_val     = (cfg.pole_pairs == 8'd0) ? 16'd0 : div_quot;
  assign sel_idx     = sel[MW-1:0];
  assign age         = tick_count - record_stamp[sel_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tick       = 1'b0;
    capture    = 1'b0;
    crc_start  = 1'b0;
    div_start  = 1'b0;
    bad_frame  = 1'b0;
    store      = 1'b0;
    read_res   = 1'b0;
    load_out   = 1'b0;
    case (state)
      esr_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            esr_pkg::CMD_TICK: tick = 1'b1;
            esr_pkg::CMD_BYTE: begin
              if (frame_active && byte_index < esr_pkg::FRAME_LEN) begin
                capture = 1'b1;
                if (byte_index == esr_pkg::LAST_BYTE) begin
                  state_next = esr_pkg::ST_CHECK;
                end else begin
                  crc_start  = 1'b1;
                  state_next = esr_pkg::ST_CRC;
                end
              end
            end
            esr_pkg::CMD_READ: state_next = esr_pkg::ST_READ;
            default: ;
          endcase
        end
      end
      esr_pkg::ST_CRC: begin
        if (crc_done) begin
          state_next = esr_pkg::ST_IDLE;
        end
      end
      esr_pkg::ST_CHECK: begin
        if (crc != frame_bytes[esr_pkg::LAST_BYTE]) begin
          bad_frame  = 1'b1;
          state_next = esr_pkg::ST_EMIT;
        end else if (cfg.pole_pairs == 8'd0) begin
          state_next = esr_pkg::ST_STORE;
        end else begin
          div_start  = 1'b1;
          state_next = esr_pkg::ST_DIV;
        end
      end
      esr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = esr_pkg::ST_STORE;
        end
      end
      esr_pkg::ST_STORE: begin
        store      = 1'b1;
        state_next = esr_pkg::ST_EMIT;
      end
      esr_pkg::ST_READ: begin
        read_res   = 1'b1;
        state_next = esr_pkg::ST_EMIT;
      end
      esr_pkg::ST_EMIT: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = esr_pkg::ST_IDLE;
        end
      end
      default: state_next = esr_pkg::ST_IDLE;
    endcase
  end

  // time base, motor rotation and frame capture control
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= 32'd0;
      divider_count  <= 8'd0;
      expected_motor <= '0;
      frame_active   <= 1'b0;
      byte_index     <= 4'd0;
    end else begin
      if (tick) begin
        tick_count    <= tick_count + 32'd1;
        divider_count <= advance ? 8'd0 : div_cnt_inc;
        if (advance) begin
          expected_motor <= (expected_motor == MW'(esr_pkg::MOTORS - 1)) ?
                            '0 : expected_motor + MW'(1);
          byte_index     <= 4'd0;
          frame_active   <= 1'b1;
        end
      end
      if (capture) begin
        byte_index <= byte_index + 4'd1;
        if (byte_index == esr_pkg::LAST_BYTE) begin
          frame_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      frame_bytes[byte_index] <= item.rx_byte;
    end
    if (accept) begin
      sel <= item.motor_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < esr_pkg::MOTORS; i++) begin
        record_rpm[i]     <= 16'd0;
        record_voltage[i] <= 16'd0;
        record_current[i] <= 16'd0;
        record_temp[i]    <= 8'd0;
        record_valid[i]   <= 1'b0;
        record_stamp[i]   <= 32'd0;
      end
    end else if (store) begin
      record_rpm[expected_motor]     <= rpm_val;
      record_voltage[expected_motor] <= {frame_bytes[1], frame_bytes[2]};
      record_current[expected_motor] <= {frame_bytes[3], frame_bytes[4]};
      record_temp[expected_motor]    <= frame_bytes[0];
      record_valid[expected_motor]   <= 1'b1;
      record_stamp[expected_motor]   <= tick_count;
    end
  end

  // pending result, built before it goes to the output register
  always_ff @(posedge clk) begin
    if (bad_frame) begin
      res.is_frame_report <= 1'b1;
      res.crc_ok          <= 1'b0;
      res.motor           <= 3'(expected_motor);
      res.rpm             <= 16'd0;
      res.supply_mv       <= 16'd0;
      res.load_current    <= 16'd0;
      res.temp_c          <= 8'd0;
      res.valid_res       <= 1'b0;
    end else if (store) begin
      res.is_frame_report <= 1'b1;
      res.crc_ok          <= 1'b1;
      res.motor           <= 3'(expected_motor);
      res.rpm             <= rpm_val;
      res.supply_mv       <= {frame_bytes[1], frame_bytes[2]};
      res.load_current    <= {frame_bytes[3], frame_bytes[4]};
      res.temp_c          <= frame_bytes[0];
      res.valid_res       <= 1'b1;
    end else if (read_res) begin
      res.is_frame_report <= 1'b0;
      res.crc_ok          <= 1'b1;
      res.motor           <= sel;
      if ({1'b0, sel} < esr_pkg::MOTORS_N) begin
        res.rpm          <= record_rpm[sel_idx];
        res.supply_mv    <= record_voltage[sel_idx];
        res.load_current <= record_current[sel_idx];
        res.temp_c       <= record_temp[sel_idx];
        res.valid_res    <= record_valid[sel_idx] && (age < {16'd0, cfg.timeout_ticks});
      end else begin
        res.rpm          <= 16'd0;
        res.supply_mv    <= 16'd0;
        res.load_current <= 16'd0;
        res.temp_c       <= 8'd0;
        res.valid_res    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/esr_cfg_regs.sv]
// APB-style configuration registers: pole pairs, request period, timeout.
// Depends on esr_pkg for the register map and the cfg_t struct.
`default_nettype none

module esr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output esr_pkg::cfg_t      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pole_pairs     <= esr_pkg::RESET_POLEPAIRS;
      cfg.request_period <= esr_pkg::RESET_PERIOD;
      cfg.timeout_ticks  <= esr_pkg::RESET_TIMEOUT;
    end else if (wr_en) begin
      case (paddr[3:2])
        esr_pkg::REG_POLE_PAIRS: cfg.pole_pairs     <= pwdata[7:0];
        esr_pkg::REG_REQ_PERIOD: cfg.request_period <= pwdata[7:0];
        esr_pkg::REG_TIMEOUT:    cfg.timeout_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      esr_pkg::REG_POLE_PAIRS: prdata = {24'd0, cfg.pole_pairs};
      esr_pkg::REG_REQ_PERIOD: prdata = {24'd0, cfg.request_period};
      esr_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ticks};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/esr_crc8_serial.sv]
// Bit-serial CRC8 (poly 0xD5, MSB first): each byte is shifted in one bit at a time.
// Depends on esr_pkg for the polynomial.
`default_nettype none

module esr_crc8_serial (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       clear,
  input  wire logic       start,
  input  wire logic [7:0] data,
  output logic            done,
  output logic [7:0]      crc
);

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] sh;
  logic       fb;

  assign fb = crc[7] ^ sh[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= 8'd0;
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        crc <= 8'd0;
      end
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        crc <= {crc[6:0], 1'b0} ^ (fb ? esr_pkg::CRC_POLY : 8'd0);
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= data;
    end else if (busy) begin
      sh <= {sh[6:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

[rtl/esr_div_serial.sv]
// Restoring divider, one quotient bit per cycle: eRPM / pole pairs, saturated
// to 16 bits. Depends on esr_pkg for the dividend width.
`default_nettype none

module esr_div_serial (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [esr_pkg::ERPM_W-1:0] dividend,
  input  wire logic [7:0]                 divisor,
  output logic                            done,
  output logic [15:0]                     quotient
);

  localparam int CNT_W = $clog2(esr_pkg::ERPM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(esr_pkg::ERPM_W - 1);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [esr_pkg::ERPM_W-1:0] dq;     // dividend shifts out, quotient shifts in
  logic [7:0]                 rem;
  logic [7:0]                 dvs;
  logic [8:0]                 rem_sh;
  logic                       qbit;

  assign rem_sh = {rem, dq[esr_pkg::ERPM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});
  assign quotient = (|dq[esr_pkg::ERPM_W-1:16]) ? 16'hFFFF : dq[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= 8'd0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[esr_pkg::ERPM_W-2:0], qbit};
      rem <= qbit ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];
    end
  end

endmodule

`default_nettype wire

[rtl/esr_checker.sv]
// Port-level checks for esc_serial_telemetry_receiver_unit, bound to the top level.
// Depends on esr_pkg for the result struct and the motor count.
`default_nettype none

module esr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire esr_pkg::out_item_t result
);

  logic zero_fields;
  assign zero_fields = (result.rpm == 16'd0) && (result.supply_mv == 16'd0) &&
                       (result.load_current == 16'd0) && (result.temp_c == 8'd0) &&
                       !result.valid_res;

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result transfer changed");

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.crc_ok |-> result.is_frame_report && zero_fields)
    else $error("bad-checksum report carries data or is a read answer");

  a_report_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_frame_report |-> result.valid_res == result.crc_ok)
    else $error("frame report validity disagrees with checksum");

  a_oor_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_frame_report &&
    ({1'b0, result.motor} >= esr_pkg::MOTORS_N) |-> zero_fields && result.crc_ok)
    else $error("read of absent motor returned data");

endmodule

bind esc_serial_telemetry_receiver_unit esr_checker u_esr_checker (.*);

`default_nettype wire

[dv/tb_esc_serial_telemetry_receiver_unit.sv]
`timescale 1ns / 100ps
// Testbench for esc_serial_telemetry_receiver_unit: directed and random command
// streams checked against an in-bench predictor of frames, records and reads.
// Depends on esr_pkg and the RTL of the unit only.

module tb_esc_serial_telemetry_receiver_unit;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;

  typedef logic [9:0][7:0] frame_t;

  typedef struct {
    esr_pkg::in_item_t payload;
    bit                wait_drain;
  } send_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  esr_pkg::in_item_t  item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  esr_pkg::out_item_t result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  esc_serial_telemetry_receiver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  send_entry_t        items_to_send[$];
  esr_pkg::out_item_t telemetry_due[$];
  int                 queued_items = 0;
  int                 awaiting = 0;
  int                 mismatches = 0;
  int                 send_idle_pct = 38;
  int                 recv_idle_pct = 48;

  // predictor state
  logic [7:0]                 pole_pairs_cfg;
  logic [7:0]                 req_period_cfg;
  logic [15:0]                timeout_cfg;
  logic [31:0]                tick_ctr;
  logic [7:0]                 div_ctr;
  logic [esr_pkg::MIDX_W-1:0] cur_motor;
  logic                       capturing;
  logic [3:0]                 byte_pos;
  frame_t                     frame_buf;
  logic [15:0]                rec_rpm     [esr_pkg::MOTORS];
  logic [15:0]                rec_voltage [esr_pkg::MOTORS];
  logic [15:0]                rec_current [esr_pkg::MOTORS];
  logic [7:0]                 rec_temp    [esr_pkg::MOTORS];
  logic                       rec_valid   [esr_pkg::MOTORS];
  logic [31:0]                rec_stamp   [esr_pkg::MOTORS];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc_dvbs2(input frame_t f);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 9; i++) begin
      c = c ^ f[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ esr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic predict_telemetry(input esr_pkg::in_item_t it, output bit produced);
    esr_pkg::out_item_t         r;
    int unsigned                erpm;
    int unsigned                q;
    logic [31:0]                age;
    logic [esr_pkg::MIDX_W-1:0] mi;
    r = '0;
    produced = 1'b0;
    mi = it.motor_select[esr_pkg::MIDX_W-1:0];
    case (it.cmd)
      esr_pkg::CMD_TICK: begin
        tick_ctr = tick_ctr + 1;
        div_ctr = div_ctr + 8'd1;
        if (div_ctr >= req_period_cfg) begin
          div_ctr = '0;
          cur_motor = (cur_motor == esr_pkg::MOTORS - 1) ? '0 : cur_motor + 1'b1;
          byte_pos = '0;
          capturing = 1'b1;
        end
      end
      esr_pkg::CMD_BYTE: begin
        if (capturing && byte_pos < esr_pkg::FRAME_LEN) begin
          frame_buf[byte_pos] = it.rx_byte;
          byte_pos = byte_pos + 4'd1;
          if (byte_pos == esr_pkg::FRAME_LEN) begin
            capturing = 1'b0;
            r.is_frame_report = 1'b1;
            r.motor = 3'(cur_motor);
            if (crc_dvbs2(frame_buf) == frame_buf[9]) begin
              erpm = {frame_buf[7], frame_buf[8]} * 100;
              q = (pole_pairs_cfg == 0) ? 0 : erpm / pole_pairs_cfg;
              rec_rpm[cur_motor] = (q > 65535) ? 16'hFFFF : q[15:0];
              rec_voltage[cur_motor] = {frame_buf[1], frame_buf[2]};
              rec_current[cur_motor] = {frame_buf[3], frame_buf[4]};
              rec_temp[cur_motor] = frame_buf[0];
              rec_valid[cur_motor] = 1'b1;
              rec_stamp[cur_motor] = tick_ctr;
              r.crc_ok = 1'b1;
              r.rpm = rec_rpm[cur_motor];
              r.supply_mv = rec_voltage[cur_motor];
              r.load_current = rec_current[cur_motor];
              r.temp_c = rec_temp[cur_motor];
              r.valid_res = 1'b1;
            end
            telemetry_due.push_back(r);
            produced = 1'b1;
          end
        end
      end
      esr_pkg::CMD_READ: begin
        r.crc_ok = 1'b1;
        r.motor = it.motor_select;
        if (it.motor_select < esr_pkg::MOTORS) begin
          age = tick_ctr - rec_stamp[mi];
          r.rpm = rec_rpm[mi];
          r.supply_mv = rec_voltage[mi];
          r.load_current = rec_current[mi];
          r.temp_c = rec_temp[mi];
          r.valid_res = rec_valid[mi] && (age < {16'h0, timeout_cfg});
        end
        telemetry_due.push_back(r);
        produced = 1'b1;
      end
      default: ;
    endcase
  endtask

  // input side: one transfer per handshake, payload held while valid is high
  always @(posedge clk) begin : drive_items
    send_entry_t nxt;
    bit          produced;
    produced = 1'b0;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) predict_telemetry(item, produced);
      awaiting = awaiting + int'(produced) - int'(result_valid && result_ready);
      if (!item_valid || item_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(items_to_send[0].wait_drain && awaiting != 0)) begin
          nxt = items_to_send.pop_front();
          item_valid <= 1'b1;
          item <= nxt.payload;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    esr_pkg::out_item_t want;
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && result_valid && result_ready) begin
      if (telemetry_due.size() == 0) begin
        $display("%0t: result with none pending, expected nothing, got %h", $time, result);
        mismatches++;
      end else begin
        want = telemetry_due.pop_front();
        check_field("is_frame_report", want.is_frame_report, result.is_frame_report);
        check_field("crc_ok", want.crc_ok, result.crc_ok);
        check_field("motor", want.motor, result.motor);
        check_field("rpm", want.rpm, result.rpm);
        check_field("supply_mv", want.supply_mv, result.supply_mv);
        check_field("load_current", want.load_current, result.load_current);
        check_field("temp_c", want.temp_c, result.temp_c);
        check_field("valid_res", want.valid_res, result.valid_res);
      end
    end
  end

  task automatic push_cmd(input logic [1:0] c, input logic [7:0] rx, input logic [2:0] sel,
                          input bit drain);
    send_entry_t e;
    e.payload.cmd = c;
    e.payload.rx_byte = rx;
    e.payload.motor_select = sel;
    e.wait_drain = drain;
    items_to_send.push_back(e);
    if (c != CMD_UNUSED) queued_items++;
  endtask

  task automatic write_reg(input esr_pkg::reg_e idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      esr_pkg::REG_POLE_PAIRS: pole_pairs_cfg = val[7:0];
      esr_pkg::REG_REQ_PERIOD: req_period_cfg = val[7:0];
      esr_pkg::REG_TIMEOUT:    timeout_cfg = val[15:0];
      default: ;
    endcase
  endtask

  // idle means nothing queued, nothing on the bus, no result outstanding
  task automatic wait_quiet();
    @(negedge clk);
    while (items_to_send.size() != 0 || item_valid || awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_traffic(input int budget);
    int     start;
    int     r;
    int     n;
    frame_t f;
    start = queued_items;
    while (queued_items - start < budget) begin
      r = $urandom_range(99);
      if (r < 50 || r >= 85) begin
        // enough ticks to open a capture window, then a full or broken frame
        n = int'(req_period_cfg) + $urandom_range(1);
        for (int k = 0; k < n; k++)
          push_cmd(esr_pkg::CMD_TICK, 8'($urandom), 3'($urandom), 1'b0);
        for (int i = 0; i < 9; i++) f[i] = 8'($urandom);
        case ($urandom_range(3))
          0: {f[7], f[8]} = 16'hFFFF;
          1: {f[7], f[8]} = 16'h0000;
          2: {f[7], f[8]} = 16'($urandom_range(700));
          default: ;
        endcase
        if ($urandom_range(7) == 0) f[0] = 8'hFF;
        f[9] = crc_dvbs2(f);
        if ($urandom_range(99) < 15) f[9] = f[9] ^ 8'($urandom_range(1, 255));
        n = (r < 50) ? 10 : $urandom_range(1, 9);
        for (int k = 0; k < n; k++) begin
          push_cmd(esr_pkg::CMD_BYTE, f[k], 3'($urandom), 1'b0);
          if ($urandom_range(9) == 0)
            push_cmd(esr_pkg::CMD_READ, 8'($urandom), 3'($urandom), 1'b0);
        end
        if ($urandom_range(2) == 0)
          push_cmd(esr_pkg::CMD_READ, 8'($urandom), 3'($urandom_range(esr_pkg::MOTORS - 1)),
                   1'b0);
      end else if (r < 65) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          push_cmd(esr_pkg::CMD_READ, 8'($urandom), 3'($urandom),
                   (k == 0) && ($urandom_range(19) == 0));
      end else if (r < 75) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          push_cmd(esr_pkg::CMD_TICK, 8'($urandom), 3'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) push_cmd(2'($urandom), 8'($urandom), 3'($urandom), 1'b0);
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] pp, input logic [7:0] rp, input logic [15:0] tmo,
                           input int budget, input int send_pct, input int recv_pct);
    wait_quiet();
    write_reg(esr_pkg::REG_POLE_PAIRS, {24'h0, pp});
    write_reg(esr_pkg::REG_REQ_PERIOD, {24'h0, rp});
    write_reg(esr_pkg::REG_TIMEOUT, {16'h0, tmo});
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_traffic(budget);
  endtask

  initial begin : stimulus
    frame_t f;
    pole_pairs_cfg = esr_pkg::RESET_POLEPAIRS;
    req_period_cfg = esr_pkg::RESET_PERIOD;
    timeout_cfg = esr_pkg::RESET_TIMEOUT;
    tick_ctr = '0;
    div_ctr = '0;
    cur_motor = '0;
    capturing = 1'b0;
    byte_pos = '0;
    frame_buf = '0;
    for (int m = 0; m < esr_pkg::MOTORS; m++) begin
      rec_rpm[m] = '0;
      rec_voltage[m] = '0;
      rec_current[m] = '0;
      rec_temp[m] = '0;
      rec_valid[m] = 1'b0;
      rec_stamp[m] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset records, out-of-range read, dropped byte, unused command,
    // a saturating good frame, a late byte, then reads with a full drain first
    push_cmd(esr_pkg::CMD_READ, 8'h00, 3'd0, 1'b0);
    push_cmd(esr_pkg::CMD_READ, 8'hFF, 3'd7, 1'b0);
    push_cmd(esr_pkg::CMD_BYTE, 8'hAA, 3'd0, 1'b0);
    push_cmd(CMD_UNUSED, 8'hFF, 3'd7, 1'b0);
    for (int k = 0; k < 4; k++) push_cmd(esr_pkg::CMD_TICK, 8'h00, 3'd0, 1'b0);
    f = '0;
    f[0] = 8'hFF;
    f[1] = 8'hFF;
    f[2] = 8'hFF;
    f[5] = 8'h5A;
    f[6] = 8'hC3;
    f[7] = 8'hFF;
    f[8] = 8'hFF;
    f[9] = crc_dvbs2(f);
    for (int k = 0; k < 10; k++) push_cmd(esr_pkg::CMD_BYTE, f[k], 3'd5, 1'b0);
    push_cmd(esr_pkg::CMD_BYTE, 8'h00, 3'd0, 1'b0);
    push_cmd(esr_pkg::CMD_READ, 8'h00, 3'd1, 1'b1);
    push_cmd(esr_pkg::CMD_READ, 8'h00, 3'd4, 1'b0);

    run_phase(8'd1, 8'd2, 16'd65535, 80, 38, 48);
    run_phase(8'd0, 8'd3, 16'd1, 70, 38, 48);
    run_phase(8'd255, 8'd1, 16'd20, 70, 48, 38);
    run_phase(8'($urandom_range(2, 254)), 8'd255, 16'd300, 60, 48, 38);
    run_phase(8'd3, 8'd5, 16'd65535, 70, 0, 0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)),
              16'($urandom_range(1, 100)), 70, 0, 0);

    wait_quiet();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
